>>> hw/rtl/cas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_pkg: shared types and constants for the capacitance autorange selector
// Range table, item structs, sequencer states and control bundles.
// ----------------------------------------------------------------------------
package cas_pkg;

	localparam int ACC_W     = 20;
	localparam int MUL_A_W   = 33;
	localparam int MUL_B_W   = 11;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 12;

	localparam logic [3:0] LAST_RANGE = 4'd15;

	// status codes
	localparam logic [1:0] STAT_NEXT    = 2'd0;
	localparam logic [1:0] STAT_DONE    = 2'd1;
	localparam logic [1:0] STAT_BACKOFF = 2'd2;
	localparam logic [1:0] STAT_OVER    = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_THR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CUR_RATIO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 2'd2;

	localparam logic [11:0] STOP_THR_RST  = 12'd3072;
	localparam logic [7:0]  CUR_RATIO_RST = 8'd20;
	localparam logic [7:0]  DELAY_RST     = 8'd59;

	typedef struct packed {
		logic [15:0] first_sum;
		logic [15:0] second_sum;
		logic        over_range;
	} cas_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  range_number;
		logic [4:0]  burst_length;
		logic [9:0]  burst_spacing;
		logic [16:0] spacing_delay;
		logic        low_current;
	} cas_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DELTA,
		ST_MUL1,
		ST_ADD,
		ST_MUL2,
		ST_CMP,
		ST_EMIT
	} cas_state_t;

	typedef enum logic [1:0] {
		MUL_PEAK,
		MUL_RATIO,
		MUL_DELAY
	} cas_mul_sel_t;

	// status from datapath into the sequencer
	typedef struct packed {
		logic go_emit;   // accepted item ends the sweep without an estimate
		logic go_est;    // accepted item completes a range, estimate needed
		logic out_free;  // output register can take a result
	} cas_sts_t;

	// control from the sequencer into the datapath
	typedef struct packed {
		logic         in_ready;
		logic         ld_delta;
		logic         ld_prod;
		logic         ld_est;
		logic         ld_cmp;
		logic         emit;
		cas_mul_sel_t mul_sel;
	} cas_ctrl_t;

	// range table
	function automatic logic [4:0] row_blen(input logic [3:0] idx);
		logic [4:0] r;
		unique case (idx)
			4'd0:    r = 5'd1;
			4'd1:    r = 5'd2;
			4'd2:    r = 5'd4;
			4'd3:    r = 5'd8;
			default: r = 5'd16;
		endcase
		return r;
	endfunction

	// log2 of the burst spacing
	function automatic logic [3:0] row_shift(input logic [3:0] idx);
		return (idx < 4'd10) ? idx : (idx - 4'd6);
	endfunction

	function automatic logic [9:0] row_bspace(input logic [3:0] idx);
		return 10'd1 << row_shift(idx);
	endfunction

	function automatic logic [4:0] row_reps(input logic [3:0] idx);
		logic [4:0] r;
		unique case (idx)
			4'd0:    r = 5'd16;
			4'd1:    r = 5'd8;
			4'd2:    r = 5'd4;
			4'd3:    r = 5'd2;
			default: r = 5'd1;
		endcase
		return r;
	endfunction

	function automatic logic row_lowcur(input logic [3:0] idx);
		return idx < 4'd10;
	endfunction

endpackage

>>> hw/rtl/cas_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_mul: shared signed multiplier
// One 33x11 signed multiply, time-shared by the sequencer.
// ----------------------------------------------------------------------------
module cas_mul
	import cas_pkg::*;
(
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p
);

	assign p = MUL_P_W'(a) * MUL_P_W'(b);

endmodule

>>> hw/rtl/cas_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_ctrl: estimate sequencer
// Steps the shared multiplier through the peak estimate and the result load.
// ----------------------------------------------------------------------------
module cas_ctrl
	import cas_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  cas_sts_t  sts,
	output cas_ctrl_t ctrl
);

	cas_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.go_emit) begin
						state_d = ST_EMIT;
					end else if (sts.go_est) begin
						state_d = ST_DELTA;
					end
				end
			end
			ST_DELTA: state_d = ST_MUL1;
			ST_MUL1:  state_d = ST_ADD;
			ST_ADD:   state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_CMP;
			ST_CMP:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.mul_sel = MUL_DELAY;
		unique case (state_q)
			ST_IDLE:  ctrl.in_ready = 1'b1;
			ST_DELTA: ctrl.ld_delta = 1'b1;
			ST_MUL1: begin
				ctrl.ld_prod = 1'b1;
				ctrl.mul_sel = MUL_PEAK;
			end
			ST_ADD:   ctrl.ld_est = 1'b1;
			ST_MUL2: begin
				ctrl.ld_prod = 1'b1;
				ctrl.mul_sel = MUL_RATIO;
			end
			ST_CMP:   ctrl.ld_cmp = 1'b1;
			ST_EMIT:  ctrl.emit = sts.out_free;
			default:  ctrl = '0;
		endcase
	end

endmodule

>>> hw/rtl/capacitance_autorange_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capacitance_autorange_selector: range sweep over a 16-entry range table
// Accumulates slope samples per range, estimates the next range's peak
// and either advances or ends the sweep.
// ----------------------------------------------------------------------------
// An item that only accumulates gives no result and the sequencer stays idle.
// An over-range item, or the last item of range 15, goes straight to EMIT. An
// item that completes ranges 0..14 runs the estimate through the shared
// multiplier in DELTA, MUL1, ADD, MUL2 and CMP before EMIT. Items are taken only
// in idle. The output register holds one pending result; EMIT waits till it is free.
// Reset: sweep at range 0, sums cleared, 16 samples left, registers at defaults.
module capacitance_autorange_selector
	import cas_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cas_in_t              in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cas_out_t             out_item,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata
);

	// ---------------------------------------------------------------- config
	logic [11:0] stop_thr_q;
	logic [7:0]  cur_ratio_q;
	logic [7:0]  delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_thr_q  <= STOP_THR_RST;
			cur_ratio_q <= CUR_RATIO_RST;
			delay_q     <= DELAY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_STOP_THR:  stop_thr_q  <= cfg_wdata;
				CFG_CUR_RATIO: cur_ratio_q <= cfg_wdata[7:0];
				CFG_DELAY:     delay_q     <= cfg_wdata[7:0];
				default:       ;
			endcase
		end
	end

	// ------------------------------------------------------------- sequencer
	cas_sts_t  sts;
	cas_ctrl_t ctrl;

	cas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.ctrl     (ctrl)
	);

	assign in_ready = ctrl.in_ready;
	logic in_fire;
	assign in_fire = in_valid & ctrl.in_ready;

	// ---------------------------------------------------------- sweep state
	logic [3:0]       range_q;
	logic [ACC_W-1:0] acc_first_q, acc_second_q;
	logic [4:0]       left_q;
	logic [1:0]       status_q;  // pending result status
	logic [3:0]       rn_q;      // pending result range

	logic       last_sample;
	logic [3:0] range_nxt;
	assign last_sample = (left_q <= 5'd1);  // zero counts as one
	assign range_nxt   = range_q + 4'd1;

	// Over-range ends the sweep at once; range 15 has no next range to estimate.
	assign sts.go_emit  = in_item.over_range | (last_sample & (range_q == LAST_RANGE));
	assign sts.go_est   = ~in_item.over_range & last_sample & (range_q != LAST_RANGE);
	assign sts.out_free = ~out_valid | out_ready;

	// -------------------------------------------------------------- datapath
	logic signed [20:0]        diff;
	logic signed [29:0]        diff256, bias, delta_d;
	logic signed [29:0]        delta_q;
	logic signed [MUL_A_W-1:0] est_q, est_d, mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p, prod_q, prod_sh8, scaled;
	logic [4:0]                blen_nxt;
	logic [9:0]                factor;
	logic                      cur_switch;
	logic                      est_over;

	// delta = diff*256 / spacing, truncated toward zero; spacing is a power of two
	assign diff    = $signed({1'b0, acc_second_q}) - $signed({1'b0, acc_first_q});
	assign diff256 = {diff[20], diff, 8'b0};
	assign bias    = diff[20] ? $signed({20'b0, row_bspace(range_q) - 10'd1}) : '0;
	assign delta_d = (diff256 + bias) >>> row_shift(range_q);

	// next range's sample point in spacing units
	assign blen_nxt   = row_blen(range_nxt);
	assign factor     = row_bspace(range_nxt) + {6'b0, blen_nxt[4:1]};
	// low to high current source switch happens between this range and the next
	assign cur_switch = row_lowcur(range_q) & ~row_lowcur(range_nxt);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.mul_sel)
			MUL_PEAK: begin
				mul_a = {{(MUL_A_W-30){delta_q[29]}}, delta_q};
				mul_b = $signed({1'b0, factor});
			end
			MUL_RATIO: begin
				mul_a = est_q;
				mul_b = cur_switch ? $signed({3'b0, cur_ratio_q}) : MUL_B_W'(1);
			end
			MUL_DELAY: begin
				mul_a = $signed({{(MUL_A_W-10){1'b0}}, row_bspace(rn_q)});
				mul_b = $signed({3'b0, delay_q});
			end
			default: ;
		endcase
	end

	cas_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	// floor shifts are arithmetic shifts
	assign prod_sh8 = prod_q >>> 8;
	assign est_d    = $signed({{(MUL_A_W-ACC_W){1'b0}}, acc_first_q}) + prod_sh8[MUL_A_W-1:0];
	assign scaled   = prod_q >>> 4;
	assign est_over = scaled > $signed({{(MUL_P_W-12){1'b0}}, stop_thr_q});

	always_ff @(posedge clk) begin
		if (ctrl.ld_delta) begin
			delta_q <= delta_d;
		end
		if (ctrl.ld_prod) begin
			prod_q <= mul_p;
		end
		if (ctrl.ld_est) begin
			est_q <= est_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q      <= '0;
			acc_first_q  <= '0;
			acc_second_q <= '0;
			left_q       <= row_reps(4'd0);
			status_q     <= STAT_DONE;
			rn_q         <= '0;
		end else begin
			if (in_fire) begin
				if (in_item.over_range) begin
					// back off one range, or flag over-range at the first range
					status_q <= (range_q != 4'd0) ? STAT_BACKOFF : STAT_OVER;
					rn_q     <= (range_q != 4'd0) ? (range_q - 4'd1) : 4'd0;
				end else begin
					acc_first_q  <= acc_first_q + {4'b0, in_item.first_sum};
					acc_second_q <= acc_second_q + {4'b0, in_item.second_sum};
					if (!last_sample) begin
						left_q <= left_q - 5'd1;
					end
					status_q <= STAT_DONE;
					rn_q     <= range_q;
				end
			end
			if (ctrl.ld_cmp) begin
				status_q <= est_over ? STAT_DONE : STAT_NEXT;
				rn_q     <= est_over ? range_q : range_nxt;
			end
			if (ctrl.emit) begin
				acc_first_q  <= '0;
				acc_second_q <= '0;
				if (status_q == STAT_NEXT) begin
					range_q <= rn_q;
					left_q  <= row_reps(rn_q);
				end else begin
					range_q <= '0;
					left_q  <= row_reps(4'd0);
				end
			end
		end
	end

	// ------------------------------------------------------- output register
	logic     out_valid_q;
	cas_out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_q.status        <= status_q;
			out_q.range_number  <= rn_q;
			out_q.burst_length  <= row_blen(rn_q);
			out_q.burst_spacing <= row_bspace(rn_q);
			out_q.spacing_delay <= ({5'b0, row_blen(rn_q)} == row_bspace(rn_q)) ?
				17'd0 : mul_p[16:0];
			out_q.low_current   <= row_lowcur(rn_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTH
	// a range is never left with zero samples to take
	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.in_ready |-> left_q != 5'd0)
		else $error("samples left is zero while idle");

	// advancing never wraps back to the first range
	a_next_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit && status_q == STAT_NEXT) |-> rn_q != 4'd0)
		else $error("advance result names range 0");

	// over-range at the first range always reports range 0
	a_over_first: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit && status_q == STAT_OVER) |-> rn_q == 4'd0)
		else $error("over-range status with nonzero range");

	// every result clears the sums and loads the output register
	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |=> (acc_first_q == '0 && acc_second_q == '0 && out_valid_q))
		else $error("sums not cleared after result");
`endif

endmodule
